### hw/rtl/cmtg_pkg.sv
package cmtg_pkg;

	localparam int FRACTION_BITS = 14;
	localparam int CORDIC_STEPS = 20;
	localparam int CW = 33;

	localparam logic signed [CW-1:0] CORDIC_START = 33'sd652032874;
	localparam logic [29:0] NORM_SCALE = 30'd960383883;
	localparam logic [29:0] TURN_ATAN [CORDIC_STEPS] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
		30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
		30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
		30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304
	};

	localparam int SLOTS = 12;
	localparam logic [3:0] LAST_SLOT = 4'd11;
	localparam logic [3:0] FIRST_SIDE = 4'd6;
	// per slot: far angle, outer ring, mid-angle normal at ring 0
	localparam logic [SLOTS-1:0] SLOT_A1 = 12'b100011011100;
	localparam logic [SLOTS-1:0] SLOT_J1 = 12'b001110001110;
	localparam logic [SLOTS-1:0] SLOT_MID = 12'b110001000000;

	localparam logic [1:0] REG_RING = 2'd0;
	localparam logic [1:0] REG_WEDGE = 2'd1;
	localparam logic [1:0] REG_RADIUS = 2'd2;

	typedef struct packed {
		logic [3:0] slot;
		logic [9:0] num_p;
		logic [9:0] num_n;
		logic [8:0] den;
		logic [8:0] ring;
		logic [7:0] rcnt;
		logic [14:0] rad;
	} job_t;

	typedef struct packed {
		logic [3:0] slot;
		logic [31:0] ph_p;
		logic [31:0] ph_n;
		logic [8:0] ring;
		logic [7:0] rcnt;
		logic [14:0] rad;
		logic signed [15:0] sy;
	} ang_t;

	typedef struct packed {
		logic [3:0] slot;
		logic signed [CW-1:0] cp;
		logic signed [CW-1:0] sp;
		logic signed [CW-1:0] cn;
		logic signed [CW-1:0] sn;
		logic [8:0] ring;
		logic [7:0] rcnt;
		logic [14:0] rad;
		logic signed [15:0] sy;
	} trig_t;

	typedef struct packed {
		logic [3:0] slot;
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] pz;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
		logic last;
	} vtx_t;

	function automatic logic signed [15:0] sat_mag(input logic [31:0] m, input logic neg);
		logic signed [15:0] r;
		if (neg) begin
			if (m >= 32'd32768) r = 16'sh8000;
			else r = -$signed(m[15:0]);
		end else begin
			if (m > 32'd32767) r = 16'sh7fff;
			else r = $signed(m[15:0]);
		end
		return r;
	endfunction

endpackage

### hw/rtl/cmtg_ifs.sv
interface cmtg_tile_if;
	logic valid;
	logic ready;
	logic [7:0] wedge_index;
	logic [7:0] ring_index;
	modport source(output valid, wedge_index, ring_index, input ready);
	modport sink(input valid, wedge_index, ring_index, output ready);
endinterface

interface cmtg_vtx_if;
	logic valid;
	logic ready;
	logic [3:0] vertex_slot;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [15:0] pos_z;
	logic signed [15:0] norm_x;
	logic signed [15:0] norm_y;
	logic signed [15:0] norm_z;
	logic last_vertex;
	modport source(output valid, vertex_slot, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
		last_vertex, input ready);
	modport sink(input valid, vertex_slot, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
		last_vertex, output ready);
endinterface

interface cmtg_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [14:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### hw/rtl/cone_mesh_tile_generator_top.sv
// Cone tile tessellator: each accepted (wedge, ring) word yields twelve vertex words, one per
// cycle while the output is not stalled, slots 0-5 for the base disk and 6-11 for the side,
// last_vertex marking slot 11. A new tile can be taken while the last slot of the previous
// one is issued; the first vertex comes out through the phase divider (42 stages), the
// CORDIC (21 stages) and the scaling and radial divider stages (30). Any output stall holds
// the whole pipeline without loss. Configuration writes are taken at any time but must only
// be issued while the block is idle.
module cone_mesh_tile_generator_top #(
	parameter int FRACTION_BITS = cmtg_pkg::FRACTION_BITS
) (
	input logic clk,
	input logic arst_n,
	cmtg_cfg_if.sink cfg,
	cmtg_tile_if.sink tile,
	cmtg_vtx_if.source vertex
);

	logic [7:0] ring_count_q;
	logic [7:0] wedge_count_q;
	logic [14:0] base_radius_q;
	logic [7:0] rcnt;
	logic [7:0] wcnt;
	logic en;
	logic job_vld, ang_vld, trig_vld, vtx_vld;
	cmtg_pkg::job_t job;
	cmtg_pkg::ang_t ang;
	cmtg_pkg::trig_t trig;
	cmtg_pkg::vtx_t vtx;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_count_q <= 8'd1;
			wedge_count_q <= 8'd3;
			base_radius_q <= 15'd8192;
		end else if (cfg.valid) begin
			case (cfg.index)
				cmtg_pkg::REG_RING: ring_count_q <= cfg.data[7:0];
				cmtg_pkg::REG_WEDGE: wedge_count_q <= cfg.data[7:0];
				cmtg_pkg::REG_RADIUS: base_radius_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign rcnt = (ring_count_q == 8'd0) ? 8'd1 : ring_count_q;
	assign wcnt = (wedge_count_q == 8'd0) ? 8'd1 : wedge_count_q;
	assign en = !vtx_vld || vertex.ready;

	cmtg_seq u_seq (
		.clk(clk), .arst_n(arst_n), .en(en), .tile(tile),
		.rcnt(rcnt), .wcnt(wcnt), .rad(base_radius_q),
		.job_vld(job_vld), .job(job)
	);

	cmtg_phase #(.FRACTION_BITS(FRACTION_BITS)) u_phase (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(job_vld), .job(job),
		.out_vld(ang_vld), .ang(ang)
	);

	cmtg_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(ang_vld), .ang(ang),
		.out_vld(trig_vld), .trig(trig)
	);

	cmtg_scale #(.FRACTION_BITS(FRACTION_BITS)) u_scale (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(trig_vld), .trig(trig),
		.out_vld(vtx_vld), .vtx(vtx)
	);

	assign vertex.valid = vtx_vld;
	assign vertex.vertex_slot = vtx.slot;
	assign vertex.pos_x = vtx.px;
	assign vertex.pos_y = vtx.py;
	assign vertex.pos_z = vtx.pz;
	assign vertex.norm_x = vtx.nx;
	assign vertex.norm_y = vtx.ny;
	assign vertex.norm_z = vtx.nz;
	assign vertex.last_vertex = vtx.last;

endmodule

### hw/rtl/cmtg_seq.sv
module cmtg_seq (
	input logic clk,
	input logic arst_n,
	input logic en,
	cmtg_tile_if.sink tile,
	input logic [7:0] rcnt,
	input logic [7:0] wcnt,
	input logic [14:0] rad,
	output logic job_vld,
	output cmtg_pkg::job_t job
);

	logic busy_q;
	logic [3:0] cnt_q;
	logic [7:0] w_q;
	logic [7:0] r_q;
	logic take;
	logic mid;

	assign tile.ready = en && (!busy_q || cnt_q == cmtg_pkg::LAST_SLOT);
	assign take = tile.valid && tile.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (en && busy_q) begin
			if (cnt_q == cmtg_pkg::LAST_SLOT) begin
				busy_q <= 1'b0;
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			w_q <= tile.wedge_index;
			r_q <= tile.ring_index;
		end
	end

	always_comb begin
		mid = cmtg_pkg::SLOT_MID[cnt_q] && (r_q == 8'd0);
		job.slot = cnt_q;
		job.num_p = {1'b0, w_q, 1'b0} + {8'd0, cmtg_pkg::SLOT_A1[cnt_q], 1'b0};
		job.num_n = mid ? {1'b0, w_q, 1'b1} : job.num_p;
		job.den = {wcnt, 1'b0};
		job.ring = {1'b0, r_q} + {8'd0, cmtg_pkg::SLOT_J1[cnt_q]};
		job.rcnt = rcnt;
		job.rad = rad;
	end

	assign job_vld = busy_q;

endmodule

### hw/rtl/cmtg_phase.sv
module cmtg_phase #(
	parameter int FRACTION_BITS = cmtg_pkg::FRACTION_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_vld,
	input cmtg_pkg::job_t job,
	output logic out_vld,
	output cmtg_pkg::ang_t ang
);

	localparam int NW = 10;
	localparam int DW = 9;
	localparam int NSTG = NW + 32;
	localparam int SYW = FRACTION_BITS + 9;
	localparam logic signed [SYW+1:0] HALF = (SYW+2)'(longint'(1) << (FRACTION_BITS - 1));
	localparam logic signed [SYW+1:0] SAT_HI = (SYW+2)'(32767);
	localparam logic signed [SYW+1:0] SAT_LO = (SYW+2)'(-32768);

	typedef struct packed {
		logic [3:0] slot;
		logic [NW-1:0] np;
		logic [NW-1:0] nn;
		logic [DW-1:0] den;
		logic [DW-1:0] rp;
		logic [DW-1:0] rn;
		logic [31:0] qp;
		logic [31:0] qn;
		logic [SYW-1:0] sn;
		logic [SYW-1:0] sq;
		logic [7:0] sr;
		logic [8:0] ring;
		logic [7:0] rcnt;
		logic [14:0] rad;
	} st_t;

	st_t init;
	st_t pipe_s [NSTG];
	logic [NSTG-1:0] vld_s;
	logic signed [SYW+1:0] sd;

	always_comb begin
		init = '0;
		init.slot = job.slot;
		init.np = job.num_p;
		init.nn = job.num_n;
		init.den = job.den;
		init.sn = (SYW'(job.ring) << FRACTION_BITS) + SYW'(job.rcnt >> 1);
		init.ring = job.ring;
		init.rcnt = job.rcnt;
		init.rad = job.rad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s <= '0;
		else if (en) vld_s <= {vld_s[NSTG-2:0], in_vld};
	end

	for (genvar k = 0; k < NSTG; k++) begin : g_stg
		st_t prv;
		st_t nxt;
		logic bp;
		logic bn;
		logic bs;
		logic [DW:0] tp;
		logic [DW:0] tn;
		logic [8:0] ts;

		if (k == 0) begin : g_first
			assign prv = init;
		end else begin : g_next
			assign prv = pipe_s[k-1];
		end

		if (k < NW) begin : g_nb
			assign bp = prv.np[NW-1-k];
			assign bn = prv.nn[NW-1-k];
		end else begin : g_nz
			assign bp = 1'b0;
			assign bn = 1'b0;
		end

		if (k < SYW) begin : g_sb
			assign bs = prv.sn[SYW-1-k];
		end else begin : g_sz
			assign bs = 1'b0;
		end

		always_comb begin
			nxt = prv;
			tp = {prv.rp, bp};
			tn = {prv.rn, bn};
			ts = {prv.sr, bs};
			if (tp >= {1'b0, prv.den}) begin
				nxt.rp = DW'(tp - {1'b0, prv.den});
				nxt.qp = {prv.qp[30:0], 1'b1};
			end else begin
				nxt.rp = tp[DW-1:0];
				nxt.qp = {prv.qp[30:0], 1'b0};
			end
			if (tn >= {1'b0, prv.den}) begin
				nxt.rn = DW'(tn - {1'b0, prv.den});
				nxt.qn = {prv.qn[30:0], 1'b1};
			end else begin
				nxt.rn = tn[DW-1:0];
				nxt.qn = {prv.qn[30:0], 1'b0};
			end
			if (k < SYW) begin
				if (ts >= {1'b0, prv.rcnt}) begin
					nxt.sr = 8'(ts - {1'b0, prv.rcnt});
					nxt.sq = {prv.sq[SYW-2:0], 1'b1};
				end else begin
					nxt.sr = ts[7:0];
					nxt.sq = {prv.sq[SYW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) pipe_s[k] <= nxt;
		end
	end

	always_comb begin
		sd = HALF - $signed({2'b00, pipe_s[NSTG-1].sq});
		ang.slot = pipe_s[NSTG-1].slot;
		ang.ph_p = pipe_s[NSTG-1].qp;
		ang.ph_n = pipe_s[NSTG-1].qn;
		ang.ring = pipe_s[NSTG-1].ring;
		ang.rcnt = pipe_s[NSTG-1].rcnt;
		ang.rad = pipe_s[NSTG-1].rad;
		if (sd > SAT_HI) ang.sy = 16'sh7fff;
		else if (sd < SAT_LO) ang.sy = 16'sh8000;
		else ang.sy = sd[15:0];
	end

	assign out_vld = vld_s[NSTG-1];

endmodule

### hw/rtl/cmtg_cordic.sv
module cmtg_cordic (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_vld,
	input cmtg_pkg::ang_t ang,
	output logic out_vld,
	output cmtg_pkg::trig_t trig
);

	localparam int CW = cmtg_pkg::CW;
	localparam int NS = cmtg_pkg::CORDIC_STEPS + 1;
	localparam logic signed [CW-1:0] QUARTER = 33'sd1073741824;
	localparam logic signed [CW-1:0] HALF_TURN = 33'sd2147483648;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic flip;
	} rot_t;

	typedef struct packed {
		logic [3:0] slot;
		rot_t p;
		rot_t n;
		logic [8:0] ring;
		logic [7:0] rcnt;
		logic [14:0] rad;
		logic signed [15:0] sy;
	} cs_t;

	function automatic rot_t fold(input logic [31:0] ph);
		rot_t r;
		logic signed [CW-1:0] z;
		z = $signed({ph[31], ph});
		r.x = cmtg_pkg::CORDIC_START;
		r.y = '0;
		r.flip = 1'b0;
		if (z > QUARTER) begin
			z = z - HALF_TURN;
			r.flip = 1'b1;
		end else if (z < -QUARTER) begin
			z = z + HALF_TURN;
			r.flip = 1'b1;
		end
		r.z = z;
		return r;
	endfunction

	function automatic rot_t rot_step(input rot_t a, input logic [4:0] sh,
		input logic signed [CW-1:0] da);
		rot_t r;
		r = a;
		if (a.z >= 0) begin
			r.x = a.x - (a.y >>> sh);
			r.y = a.y + (a.x >>> sh);
			r.z = a.z - da;
		end else begin
			r.x = a.x + (a.y >>> sh);
			r.y = a.y - (a.x >>> sh);
			r.z = a.z + da;
		end
		return r;
	endfunction

	cs_t pipe_s [NS];
	logic [NS-1:0] vld_s;
	cs_t last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s <= '0;
		else if (en) vld_s <= {vld_s[NS-2:0], in_vld};
	end

	for (genvar k = 0; k < NS; k++) begin : g_stg
		cs_t nxt;
		if (k == 0) begin : g_fold
			always_comb begin
				nxt.slot = ang.slot;
				nxt.p = fold(ang.ph_p);
				nxt.n = fold(ang.ph_n);
				nxt.ring = ang.ring;
				nxt.rcnt = ang.rcnt;
				nxt.rad = ang.rad;
				nxt.sy = ang.sy;
			end
		end else begin : g_rot
			localparam logic signed [CW-1:0] DA = $signed({3'b000, cmtg_pkg::TURN_ATAN[k-1]});
			always_comb begin
				nxt = pipe_s[k-1];
				nxt.p = rot_step(pipe_s[k-1].p, 5'(k - 1), DA);
				nxt.n = rot_step(pipe_s[k-1].n, 5'(k - 1), DA);
			end
		end
		always_ff @(posedge clk) begin
			if (en) pipe_s[k] <= nxt;
		end
	end

	always_comb begin
		last = pipe_s[NS-1];
		trig.slot = last.slot;
		trig.cp = last.p.flip ? -last.p.x : last.p.x;
		trig.sp = last.p.flip ? -last.p.y : last.p.y;
		trig.cn = last.n.flip ? -last.n.x : last.n.x;
		trig.sn = last.n.flip ? -last.n.y : last.n.y;
		trig.ring = last.ring;
		trig.rcnt = last.rcnt;
		trig.rad = last.rad;
		trig.sy = last.sy;
	end

	assign out_vld = vld_s[NS-1];

endmodule

### hw/rtl/cmtg_scale.sv
module cmtg_scale #(
	parameter int FRACTION_BITS = cmtg_pkg::FRACTION_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_vld,
	input cmtg_pkg::trig_t trig,
	output logic out_vld,
	output cmtg_pkg::vtx_t vtx
);

	localparam int TW = 27;
	localparam int NRS = 60 - FRACTION_BITS;
	localparam longint HALF = longint'(1) << (FRACTION_BITS - 1);
	localparam logic signed [15:0] NEG_HALF = (HALF > 32768) ? 16'sh8000 : 16'(-HALF);
	localparam longint NY_FULL = (longint'(cmtg_pkg::NORM_SCALE) +
		(longint'(1) << (30 - FRACTION_BITS))) >> (31 - FRACTION_BITS);
	localparam logic signed [15:0] NY = (NY_FULL > 32767) ? 16'sh7fff : 16'(NY_FULL);

	typedef struct packed {
		logic [3:0] slot;
		logic [TW-1:0] tx;
		logic [TW-1:0] tz;
		logic [7:0] rx;
		logic [7:0] rz;
		logic [TW-1:0] qx;
		logic [TW-1:0] qz;
		logic sx;
		logic sz;
		logic [7:0] rcnt;
		logic signed [15:0] sy;
		logic signed [15:0] nx;
		logic signed [15:0] nz;
	} dv_t;

	// magnitude and sign split
	logic [3:0] slot_s1;
	logic [31:0] axp_s1, azp_s1, axn_s1, azn_s1;
	logic sxp_s1, szp_s1, sxn_s1, szn_s1;
	logic [23:0] jr_s1;
	logic [7:0] rcnt_s1;
	logic signed [15:0] sy_s1;
	// products
	logic [3:0] slot_s2;
	logic [55:0] mx_s2, mz_s2;
	logic [61:0] nxm_s2, nzm_s2;
	logic sxp_s2, szp_s2, sxn_s2, szn_s2;
	logic [7:0] rcnt_s2;
	logic signed [15:0] sy_s2;

	logic [1:0] vld_s;
	dv_t init;
	dv_t div_s [TW];
	logic [TW-1:0] dvld_s;
	logic out_vld_q;
	cmtg_pkg::vtx_t out_q;
	cmtg_pkg::vtx_t nxt_out;
	logic [56:0] ex;
	logic [56:0] ez;
	logic [63:0] rnx;
	logic [63:0] rnz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			dvld_s <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s <= {vld_s[0], in_vld};
			dvld_s <= {dvld_s[TW-2:0], vld_s[1]};
			out_vld_q <= dvld_s[TW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			slot_s1 <= trig.slot;
			sxp_s1 <= trig.cp < 0;
			szp_s1 <= trig.sp < 0;
			sxn_s1 <= trig.cn < 0;
			szn_s1 <= trig.sn < 0;
			axp_s1 <= 32'((trig.cp < 0) ? -trig.cp : trig.cp);
			azp_s1 <= 32'((trig.sp < 0) ? -trig.sp : trig.sp);
			axn_s1 <= 32'((trig.cn < 0) ? -trig.cn : trig.cn);
			azn_s1 <= 32'((trig.sn < 0) ? -trig.sn : trig.sn);
			jr_s1 <= 24'(trig.ring) * 24'(trig.rad);
			rcnt_s1 <= trig.rcnt;
			sy_s1 <= trig.sy;

			slot_s2 <= slot_s1;
			mx_s2 <= 56'(axp_s1) * 56'(jr_s1);
			mz_s2 <= 56'(azp_s1) * 56'(jr_s1);
			nxm_s2 <= 62'(axn_s1) * 62'(cmtg_pkg::NORM_SCALE);
			nzm_s2 <= 62'(azn_s1) * 62'(cmtg_pkg::NORM_SCALE);
			sxp_s2 <= sxp_s1;
			szp_s2 <= szp_s1;
			sxn_s2 <= sxn_s1;
			szn_s2 <= szn_s1;
			rcnt_s2 <= rcnt_s1;
			sy_s2 <= sy_s1;
		end
	end

	// rounding, then the quotient by the ring count comes out one bit a stage
	always_comb begin
		ex = 57'(mx_s2) + (57'(rcnt_s2) << 29);
		ez = 57'(mz_s2) + (57'(rcnt_s2) << 29);
		rnx = (64'(nxm_s2) + (64'(1) << (NRS - 1))) >> NRS;
		rnz = (64'(nzm_s2) + (64'(1) << (NRS - 1))) >> NRS;
		init = '0;
		init.slot = slot_s2;
		init.tx = ex[56:30];
		init.tz = ez[56:30];
		init.sx = sxp_s2;
		init.sz = szp_s2;
		init.rcnt = rcnt_s2;
		init.sy = sy_s2;
		init.nx = cmtg_pkg::sat_mag(rnx[31:0], sxn_s2);
		init.nz = cmtg_pkg::sat_mag(rnz[31:0], szn_s2);
	end

	for (genvar k = 0; k < TW; k++) begin : g_div
		dv_t prv;
		dv_t nxt;
		logic [8:0] tx;
		logic [8:0] tz;
		if (k == 0) begin : g_first
			assign prv = init;
		end else begin : g_next
			assign prv = div_s[k-1];
		end
		always_comb begin
			nxt = prv;
			tx = {prv.rx, prv.tx[TW-1-k]};
			tz = {prv.rz, prv.tz[TW-1-k]};
			if (tx >= {1'b0, prv.rcnt}) begin
				nxt.rx = 8'(tx - {1'b0, prv.rcnt});
				nxt.qx = {prv.qx[TW-2:0], 1'b1};
			end else begin
				nxt.rx = tx[7:0];
				nxt.qx = {prv.qx[TW-2:0], 1'b0};
			end
			if (tz >= {1'b0, prv.rcnt}) begin
				nxt.rz = 8'(tz - {1'b0, prv.rcnt});
				nxt.qz = {prv.qz[TW-2:0], 1'b1};
			end else begin
				nxt.rz = tz[7:0];
				nxt.qz = {prv.qz[TW-2:0], 1'b0};
			end
		end
		always_ff @(posedge clk) begin
			if (en) div_s[k] <= nxt;
		end
	end

	always_comb begin
		nxt_out.slot = div_s[TW-1].slot;
		nxt_out.px = cmtg_pkg::sat_mag(32'(div_s[TW-1].qx), div_s[TW-1].sx);
		nxt_out.pz = cmtg_pkg::sat_mag(32'(div_s[TW-1].qz), div_s[TW-1].sz);
		nxt_out.last = div_s[TW-1].slot == cmtg_pkg::LAST_SLOT;
		if (div_s[TW-1].slot < cmtg_pkg::FIRST_SIDE) begin
			nxt_out.py = NEG_HALF;
			nxt_out.nx = '0;
			nxt_out.ny = NEG_HALF;
			nxt_out.nz = '0;
		end else begin
			nxt_out.py = div_s[TW-1].sy;
			nxt_out.nx = div_s[TW-1].nx;
			nxt_out.ny = NY;
			nxt_out.nz = div_s[TW-1].nz;
		end
	end

	always_ff @(posedge clk) begin
		if (en) out_q <= nxt_out;
	end

	assign out_vld = out_vld_q;
	assign vtx = out_q;

endmodule

### tb/sv/tb_cone_mesh_tile_generator_top.sv
`timescale 1ns / 1ps

module tb_cone_mesh_tile_generator_top;

	logic clk;
	logic arst_n;
	cmtg_cfg_if cfg();
	cmtg_tile_if tile();
	cmtg_vtx_if vertex();

	cone_mesh_tile_generator_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.tile(tile),
		.vertex(vertex)
	);

	localparam longint ONE_TURN = 64'sd1 << 32;
	localparam longint NORM_K = 64'sd960383883;
	localparam int SETTLE_CYCLES = 200;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	cmtg_pkg::vtx_t pending_vertices[$];
	longint unsigned ring_cfg, wedge_cfg, radius_cfg;
	int errors;
	int hold_off;
	bit send_gaps, recv_gaps;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#5ms;
		$display("Regression FAIL");
		$finish;
	end

	function automatic longint round_half_away(input longint n, input longint d);
		if (n >= 0) return (n + d / 2) / d;
		return -((-n + d / 2) / d);
	endfunction

	function automatic logic [15:0] clamp16(input longint v);
		if (v > 32767) return 16'h7fff;
		if (v < -32768) return 16'h8000;
		return v[15:0];
	endfunction

	function automatic logic [31:0] turn_phase(input longint unsigned num,
		input longint unsigned den);
		longint unsigned q;
		q = (num << 32) / den;
		return q[31:0];
	endfunction

	// rotation cordic in q30, angle folded into the right half plane
	function automatic void rotate(input logic [31:0] ph, output longint c, output longint s);
		longint z, x, y, nx;
		bit flip;
		z = longint'({32'b0, ph});
		x = 64'sd652032874;
		y = 0;
		flip = 0;
		if (z >= ONE_TURN / 2) z -= ONE_TURN;
		if (z > ONE_TURN / 4) begin
			z -= ONE_TURN / 2;
			flip = 1;
		end else if (z < -(ONE_TURN / 4)) begin
			z += ONE_TURN / 2;
			flip = 1;
		end
		for (int i = 0; i < cmtg_pkg::CORDIC_STEPS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= longint'(cmtg_pkg::TURN_ATAN[i]);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += longint'(cmtg_pkg::TURN_ATAN[i]);
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic void tessellate_tile(input logic [7:0] w, input logic [7:0] r);
		int side_far[6] = '{1, 1, 0, 0, 0, 1};
		int outer[6] = '{0, 1, 1, 1, 0, 0};
		int base_far[6] = '{0, 0, 1, 1, 1, 0};
		longint rc, rad, half, nd, ny;
		longint unsigned wc;
		longint cs[3], sn[3], px[2][2], pz[2][2], sy[2], nx[3], nz[3];
		longint ring;
		int a, j, ni;
		cmtg_pkg::vtx_t v;
		rc = ring_cfg ? longint'(ring_cfg) : 1;
		wc = wedge_cfg ? wedge_cfg : 1;
		rad = longint'(radius_cfg);
		half = 64'sd1 << (cmtg_pkg::FRACTION_BITS - 1);
		rotate(turn_phase(w, wc), cs[0], sn[0]);
		rotate(turn_phase(w + 1, wc), cs[1], sn[1]);
		rotate(turn_phase(2 * w + 1, 2 * wc), cs[2], sn[2]);
		for (int jj = 0; jj < 2; jj++) begin
			ring = longint'(r) + jj;
			for (int aa = 0; aa < 2; aa++) begin
				px[aa][jj] = round_half_away(cs[aa] * ring * rad, rc << 30);
				pz[aa][jj] = round_half_away(sn[aa] * ring * rad, rc << 30);
			end
			sy[jj] = half - round_half_away(ring << cmtg_pkg::FRACTION_BITS, rc);
		end
		nd = 64'sd1 << (60 - cmtg_pkg::FRACTION_BITS);
		ny = round_half_away(NORM_K, 64'sd1 << (31 - cmtg_pkg::FRACTION_BITS));
		for (int k = 0; k < 3; k++) begin
			nx[k] = round_half_away(cs[k] * NORM_K, nd);
			nz[k] = round_half_away(sn[k] * NORM_K, nd);
		end
		for (int k = 0; k < 12; k++) begin
			v.slot = k[3:0];
			v.last = (k == 11);
			if (k < 6) begin
				a = base_far[k];
				j = outer[k];
				v.py = clamp16(-half);
				v.nx = 16'sd0;
				v.ny = clamp16(-half);
				v.nz = 16'sd0;
			end else begin
				a = side_far[k - 6];
				j = outer[k - 6];
				v.py = clamp16(sy[j]);
				if (k == 7) ni = 1;
				else if (k == 8 || k == 9) ni = 0;
				else if (r == 0) ni = 2;
				else if (k == 10) ni = 0;
				else ni = 1;
				v.nx = clamp16(nx[ni]);
				v.ny = clamp16(ny);
				v.nz = clamp16(nz[ni]);
			end
			v.px = clamp16(px[a][j]);
			v.pz = clamp16(pz[a][j]);
			pending_vertices = {pending_vertices, v};
		end
	endfunction

	task automatic send_tile(input logic [7:0] w, input logic [7:0] r);
		int gap;
		gap = send_gaps ? $urandom_range(0, 7) : 0;
		repeat (gap) begin
			@(negedge clk);
			tile.valid <= 1'b0;
		end
		@(negedge clk);
		tile.valid <= 1'b1;
		tile.wedge_index <= w;
		tile.ring_index <= r;
		do @(posedge clk); while (!tile.ready);
		tessellate_tile(w, r);
	endtask

	task automatic drain;
		@(negedge clk);
		tile.valid <= 1'b0;
		wait (pending_vertices.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [14:0] value);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			cmtg_pkg::REG_RING: ring_cfg = value[7:0];
			cmtg_pkg::REG_WEDGE: wedge_cfg = value[7:0];
			cmtg_pkg::REG_RADIUS: radius_cfg = value;
			default: ;
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic set_shape(input logic [14:0] rings, input logic [14:0] wedges,
		input logic [14:0] radius);
		drain();
		write_reg(cmtg_pkg::REG_RING, rings);
		write_reg(cmtg_pkg::REG_WEDGE, wedges);
		write_reg(cmtg_pkg::REG_RADIUS, radius);
	endtask

	task automatic test_reset_defaults;
		send_tile(8'd0, 8'd0);
		send_tile(8'd1, 8'd0);
		send_tile(8'd2, 8'd0);
	endtask

	task automatic test_extremes;
		set_shape(15'd255, 15'd255, 15'd32767);
		send_tile(8'd0, 8'd0);
		send_tile(8'd254, 8'd254);
		send_tile(8'd255, 8'd255);
		send_tile(8'd127, 8'd128);
		set_shape(15'd1, 15'd3, 15'd0);
		send_tile(8'd2, 8'd0);
		set_shape(15'd2, 15'd4, 15'd32767);
		send_tile(8'd255, 8'd255);
		send_tile(8'd5, 8'd9);
		send_tile(8'd3, 8'd1);
	endtask

	task automatic test_zero_counts;
		// upper data bits are dropped by the 8-bit count registers
		set_shape(15'h7f00, 15'h5500, 15'd16384);
		send_tile(8'd0, 8'd0);
		send_tile(8'd0, 8'd1);
		send_tile(8'd170, 8'd85);
		drain();
		write_reg(REG_UNUSED, 15'h7fff);
		send_tile(8'd1, 8'd0);
	endtask

	task automatic test_backpressure;
		set_shape(15'd4, 15'd8, 15'd8192);
		send_gaps = 0;
		hold_off = 400;
		repeat (20) send_tile(8'($urandom_range(0, 7)), 8'($urandom_range(0, 3)));
		send_gaps = 1;
	endtask

	task automatic test_drain_pause;
		send_tile(8'd1, 8'd2);
		drain();
		send_tile(8'd6, 8'd3);
	endtask

	task automatic test_random_tiles;
		logic [7:0] rc, wc, w, r;
		for (int ph = 0; ph < 6; ph++) begin
			rc = (ph == 5) ? 8'd255 : 8'($urandom_range(1, 12));
			wc = (ph == 4) ? 8'd255 : 8'($urandom_range(3, 40));
			set_shape({7'd0, rc}, {7'd0, wc}, 15'($urandom_range(0, 32767)));
			send_gaps = (ph != 2);
			recv_gaps = (ph != 3);
			repeat (27) begin
				if ($urandom_range(0, 9) < 8) begin
					w = 8'($urandom_range(0, wc - 1));
					r = 8'($urandom_range(0, rc - 1));
				end else begin
					w = 8'($urandom_range(0, 255));
					r = 8'($urandom_range(0, 255));
				end
				send_tile(w, r);
			end
		end
		send_gaps = 1;
		recv_gaps = 1;
	endtask

	initial begin
		int stall;
		forever begin
			stall = recv_gaps ? $urandom_range(0, 7) : 0;
			repeat (stall) begin
				@(negedge clk);
				vertex.ready <= 1'b0;
			end
			while (hold_off > 0) begin
				@(negedge clk);
				vertex.ready <= 1'b0;
				hold_off--;
			end
			@(negedge clk);
			vertex.ready <= 1'b1;
			do @(posedge clk); while (!vertex.valid);
		end
	end

	always @(posedge clk) begin
		cmtg_pkg::vtx_t e;
		if (arst_n && vertex.valid && vertex.ready) begin
			if (pending_vertices.size() == 0) begin
				$error("unexpected vertex word, slot %0d", vertex.vertex_slot);
				errors++;
			end else begin
				e = pending_vertices.pop_front();
				if (vertex.vertex_slot !== e.slot) begin
					$error("vertex_slot exp %0d got %0d", e.slot, vertex.vertex_slot);
					errors++;
				end
				if (vertex.pos_x !== e.px) begin
					$error("pos_x exp %0d got %0d", e.px, vertex.pos_x);
					errors++;
				end
				if (vertex.pos_y !== e.py) begin
					$error("pos_y exp %0d got %0d", e.py, vertex.pos_y);
					errors++;
				end
				if (vertex.pos_z !== e.pz) begin
					$error("pos_z exp %0d got %0d", e.pz, vertex.pos_z);
					errors++;
				end
				if (vertex.norm_x !== e.nx) begin
					$error("norm_x exp %0d got %0d", e.nx, vertex.norm_x);
					errors++;
				end
				if (vertex.norm_y !== e.ny) begin
					$error("norm_y exp %0d got %0d", e.ny, vertex.norm_y);
					errors++;
				end
				if (vertex.norm_z !== e.nz) begin
					$error("norm_z exp %0d got %0d", e.nz, vertex.norm_z);
					errors++;
				end
				if (vertex.last_vertex !== e.last) begin
					$error("last_vertex exp %0d got %0d", e.last, vertex.last_vertex);
					errors++;
				end
			end
		end
	end

	initial begin
		errors = 0;
		hold_off = 0;
		send_gaps = 1;
		recv_gaps = 1;
		ring_cfg = 1;
		wedge_cfg = 3;
		radius_cfg = 8192;
		arst_n = 1'b0;
		tile.valid = 1'b0;
		tile.wedge_index = '0;
		tile.ring_index = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		vertex.ready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_defaults();
		test_extremes();
		test_zero_counts();
		test_backpressure();
		test_drain_pause();
		test_random_tiles();
		drain();
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
